>>> rtl/core/atbs_pkg.sv
// Shared types, constants and arithmetic helpers for the bull's-eye scanner.
`timescale 1ns / 1ps

package atbs_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAX_UNIT     = 2'd2;

  // Configuration reset values
  localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [7:0]  MAX_UNIT_RST     = 8'd80;

  // Frame and row limits
  localparam logic [12:0] MIN_DIM    = 13'd3;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  // Running sum
  localparam logic [12:0] SUM_INIT = 13'd128;

  // Reciprocal multipliers: floor(x/30) for x < 8192, floor(y/60) for y < 16384
  localparam logic [13:0] DIV30_MUL   = 14'd8739;
  localparam int          DIV30_SHIFT = 18;
  localparam logic [14:0] DIV60_MUL   = 15'd17477;
  localparam int          DIV60_SHIFT = 20;

  // Threshold ratio 0.975 as 39/40
  localparam logic [13:0] TH_GRAY_MUL = 14'd40;
  localparam logic [13:0] TH_THR_MUL  = 14'd39;

  // Run counters saturate here
  localparam logic [11:0] RUN_MAX = 12'd4095;

  // Input queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Per-row run-length machine
  typedef enum logic [1:0] {
    RUN_WHITE  = 2'd0,
    RUN_BLACK1 = 2'd1,
    RUN_GAP    = 2'd2,
    RUN_BLACK2 = 2'd3
  } run_level_t;

  // Control bits that travel with each pixel
  typedef struct packed {
    logic frame_start;
    logic row_first;
  } pix_flags_t;

  localparam int FLAGS_W = $bits(pix_flags_t);

  function automatic logic [8:0] div30(input logic [12:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(DIV30_MUL);
    return 9'(p >> DIV30_SHIFT);
  endfunction

  function automatic logic [8:0] div60(input logic [13:0] y);
    logic [28:0] p;
    p = 29'(y) * 29'(DIV60_MUL);
    return 9'(p >> DIV60_SHIFT);
  endfunction

  function automatic logic [11:0] sat_inc(input logic [11:0] v);
    return (v < RUN_MAX) ? v + 12'd1 : RUN_MAX;
  endfunction

  function automatic logic [12:0] used_height(input logic [12:0] h);
    logic [12:0] r;
    r = h;
    if (h < MIN_DIM) begin
      r = MIN_DIM;
    end else if (h > MAX_HEIGHT) begin
      r = MAX_HEIGHT;
    end
    return r;
  endfunction

  // Advance a row index, wrapping after the last row of the frame
  function automatic logic [11:0] next_row(input logic [11:0] row, input logic [12:0] h);
    logic [12:0] inc;
    inc = 13'(row) + 13'd1;
    return (inc >= h) ? 12'd0 : inc[11:0];
  endfunction

endpackage

>>> rtl/core/adaptive_threshold_bullseye_scan.sv
// Pixel words pass the queue, the stage 1 and 2 registers and the output register.
// Throughput: one pixel word per cycle unless stalled; the leaky-sum loop (one
// reciprocal multiply and add per cycle) and one-port line store read set that rate.
// Reset: configuration returns to 640 x 480 with max unit 80, sum to 128, counters,
// run machine and queue clear; the line store is not cleared and needs no sweep.
`timescale 1ns / 1ps

module adaptive_threshold_bullseye_scan #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_gray,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_white,
  output logic        out_mark_valid,
  output logic [11:0] out_mark_column,
  output logic [11:0] out_pixel_row,
  output logic [11:0] out_pixel_column
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int DW = 8 + 12 + CW + atbs_pkg::FLAGS_W;

  logic [12:0] image_width_r;
  logic [12:0] image_height_r;
  logic [7:0]  max_unit_r;

  logic                 q_push, q_full, q_pop, q_empty;
  logic [7:0]           f_gray;
  logic [11:0]          f_row;
  logic [CW-1:0]        f_col;
  atbs_pkg::pix_flags_t f_flags;
  logic [DW-1:0]        q_in, q_out;
  logic [7:0]           b_gray;
  logic [11:0]          b_row;
  logic [CW-1:0]        b_col;
  atbs_pkg::pix_flags_t b_flags;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= atbs_pkg::IMAGE_WIDTH_RST;
      image_height_r <= atbs_pkg::IMAGE_HEIGHT_RST;
      max_unit_r     <= atbs_pkg::MAX_UNIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atbs_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        atbs_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        atbs_pkg::CFG_MAX_UNIT:     max_unit_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  atbs_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_image_width  (image_width_r),
    .cfg_image_height (image_height_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_gray          (in_gray),
    .in_frame_start   (in_frame_start),
    .q_full           (q_full),
    .q_push           (q_push),
    .item_gray        (f_gray),
    .item_row         (f_row),
    .item_col         (f_col),
    .item_flags       (f_flags)
  );

  // Pack and unpack the queued pixel word
  assign q_in = {f_gray, f_row, f_col, f_flags};
  assign {b_gray, b_row, b_col, b_flags} = q_out;

  atbs_queue #(
    .DW (DW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  atbs_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_image_width  (image_width_r),
    .cfg_max_unit     (max_unit_r),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_gray           (b_gray),
    .q_row            (b_row),
    .q_col            (b_col),
    .q_flags          (b_flags),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_white     (out_is_white),
    .out_mark_valid   (out_mark_valid),
    .out_mark_column  (out_mark_column),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_column (out_pixel_column)
  );

endmodule

>>> rtl/core/atbs_front.sv
// Front end: accepts pixel words, tracks row and serpentine column, tags row starts.
`timescale 1ns / 1ps

module atbs_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [12:0]                cfg_image_width,
  input  logic [12:0]                cfg_image_height,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_gray,
  input  logic                       in_frame_start,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [7:0]                 item_gray,
  output logic [11:0]                item_row,
  output logic [$clog2(MAX_WIDTH)-1:0] item_col,
  output atbs_pkg::pix_flags_t       item_flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > 13) ? WW : 13;

  logic [CW-1:0] step_r, step_nxt, step_cur;
  logic [11:0]   row_r, row_nxt, row_cur;
  logic [EW-1:0] w_ext;
  logic [WW-1:0] w;
  logic [12:0]   h;
  logic [WW-1:0] step_inc;
  logic          accept;

  // Clamp the width register to the supported range
  always_comb begin
    w_ext = EW'(cfg_image_width);
    if (w_ext < EW'(3)) begin
      w_ext = EW'(3);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_ext = EW'(MAX_WIDTH);
    end
    w = WW'(w_ext);
    h = atbs_pkg::used_height(cfg_image_height);
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Resolve this pixel's row and step, then the position of the next one
  always_comb begin
    if (in_frame_start) begin
      row_cur  = 12'd0;
      step_cur = '0;
    end else if (WW'(step_r) >= w) begin
      row_cur  = atbs_pkg::next_row(row_r, h);
      step_cur = '0;
    end else begin
      row_cur  = row_r;
      step_cur = step_r;
    end

    step_inc = WW'(step_cur) + WW'(1);
    if (step_inc >= w) begin
      step_nxt = '0;
      row_nxt  = atbs_pkg::next_row(row_cur, h);
    end else begin
      step_nxt = CW'(step_inc);
      row_nxt  = row_cur;
    end

    item_gray              = in_gray;
    item_row               = row_cur;
    item_col               = row_cur[0] ? CW'(w - WW'(1) - WW'(step_cur)) : step_cur;
    item_flags.frame_start = in_frame_start;
    item_flags.row_first   = (step_cur == '0);
  end

  // Advance position counters on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      row_r  <= 12'd0;
    end else if (accept) begin
      step_r <= step_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

>>> rtl/core/atbs_queue.sv
// Short FIFO that decouples the pixel front end from the threshold back end.
`timescale 1ns / 1ps

module atbs_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  logic [DW-1:0]                 data_r [atbs_pkg::QUEUE_DEPTH];
  logic [atbs_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [atbs_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [atbs_pkg::QUEUE_AW:0]   count_r, count_nxt;

  assign full     = (count_r == (atbs_pkg::QUEUE_AW + 1)'(atbs_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = data_r[rd_ptr_r];

  // Move pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + atbs_pkg::QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + atbs_pkg::QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (atbs_pkg::QUEUE_AW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (atbs_pkg::QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/atbs_back.sv
// Back end: running sum, line store, adaptive threshold and bull's-eye run machine.
`timescale 1ns / 1ps

module atbs_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [12:0]                  cfg_image_width,
  input  logic [7:0]                   cfg_max_unit,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  logic [7:0]                   q_gray,
  input  logic [11:0]                  q_row,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  input  atbs_pkg::pix_flags_t         q_flags,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_is_white,
  output logic                         out_mark_valid,
  output logic [11:0]                  out_mark_column,
  output logic [11:0]                  out_pixel_row,
  output logic [11:0]                  out_pixel_column
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > 13) ? WW : 13;
  localparam int OW = ((CW > 13) ? CW : 13) + 1;

  // Pipeline control
  logic adv;

  // Stage 1: running sum and line store read
  logic [12:0]   sum_r, sum_base, sum_nxt;
  logic [12:0]   line_mem [MAX_WIDTH];
  logic [12:0]   line_rd_r;
  logic          s1_valid_r;
  logic [7:0]    s1_gray_r;
  logic [11:0]   s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_first_r;
  logic [8:0]    thr;

  // Stage 2: threshold ready
  logic          s2_valid_r;
  logic [8:0]    s2_thr_r;
  logic [7:0]    s2_gray_r;
  logic [11:0]   s2_row_r;
  logic [CW-1:0] s2_col_r;
  logic          s2_first_r;

  // Run machine
  atbs_pkg::run_level_t level_r, level_cur, level_nxt;
  logic [11:0] b1_r, b1_cur, b1_nxt;
  logic [11:0] wr_r, wr_cur, wr_nxt;
  logic [11:0] b2_r, b2_cur, b2_nxt;
  logic        white;
  logic [13:0] gray_scaled, thr_scaled;
  logic [12:0] run_sum, run_diff, run_off;
  logic [11:0] black_diff;
  logic        pattern_ok, mark_hit;
  logic [OW-1:0] col_ext, off_ext, w_ext_o, mcol_full;
  logic [11:0]   mark_col;

  // Output register
  logic        out_valid_r;
  logic        out_is_white_r;
  logic        out_mark_valid_r;
  logic [11:0] out_mark_column_r;
  logic [11:0] out_pixel_row_r;
  logic [11:0] out_pixel_column_r;

  logic [EW-1:0] w_clamp;
  logic [WW-1:0] w;

  // Clamp the width register to the supported range
  always_comb begin
    w_clamp = EW'(cfg_image_width);
    if (w_clamp < EW'(3)) begin
      w_clamp = EW'(3);
    end else if (w_clamp > EW'(MAX_WIDTH)) begin
      w_clamp = EW'(MAX_WIDTH);
    end
    w = WW'(w_clamp);
  end

  // Freeze the whole pipe while a finished word waits
  assign adv   = !(out_valid_r && out_stall);
  assign q_pop = adv && !q_empty;

  // Leaky running sum for the word at the queue head
  always_comb begin
    sum_base = q_flags.frame_start ? atbs_pkg::SUM_INIT : sum_r;
    sum_nxt  = 13'(14'(sum_base) + 14'(q_gray) - 14'(atbs_pkg::div30(sum_base)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= atbs_pkg::SUM_INIT;
    end else if (q_pop) begin
      sum_r <= sum_nxt;
    end
  end

  // Line store: read the previous row's sum, then overwrite with this row's
  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_rd_r       <= line_mem[q_col];
      line_mem[q_col] <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_gray_r  <= q_gray;
      s1_row_r   <= q_row;
      s1_col_r   <= q_col;
      s1_first_r <= q_flags.row_first;
    end
  end

  // Threshold: own sum on the first row, else average with the row above
  always_comb begin
    if (s1_row_r == 12'd0) begin
      thr = atbs_pkg::div30(sum_r);
    end else begin
      thr = atbs_pkg::div60(14'(sum_r) + 14'(line_rd_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_thr_r   <= thr;
      s2_gray_r  <= s1_gray_r;
      s2_row_r   <= s1_row_r;
      s2_col_r   <= s1_col_r;
      s2_first_r <= s1_first_r;
    end
  end

  // Binarize against 39/40 of the threshold
  always_comb begin
    gray_scaled = 14'(s2_gray_r) * atbs_pkg::TH_GRAY_MUL;
    thr_scaled  = 14'(s2_thr_r) * atbs_pkg::TH_THR_MUL;
    white       = !(gray_scaled < thr_scaled);
  end

  // Check the black-white-black pattern and locate its centre
  always_comb begin
    level_cur = s2_first_r ? atbs_pkg::RUN_WHITE : level_r;
    b1_cur    = s2_first_r ? 12'd0 : b1_r;
    wr_cur    = s2_first_r ? 12'd0 : wr_r;
    b2_cur    = s2_first_r ? 12'd0 : b2_r;

    run_sum    = 13'(b1_cur) + 13'(b2_cur);
    run_diff   = (run_sum > 13'(wr_cur)) ? run_sum - 13'(wr_cur) : 13'(wr_cur) - run_sum;
    black_diff = (b1_cur > b2_cur) ? b1_cur - b2_cur : b2_cur - b1_cur;
    pattern_ok = (b1_cur >= 12'd2) && (b2_cur >= 12'd2) &&
                 (b1_cur <= 12'(cfg_max_unit)) && (b2_cur <= 12'(cfg_max_unit)) &&
                 (wr_cur <= (12'(cfg_max_unit) << 1)) &&
                 (run_diff <= run_sum) && (run_diff <= 13'(wr_cur)) &&
                 (black_diff <= b1_cur) && (black_diff <= b2_cur);
    run_off    = 13'd1 + 13'(b2_cur) + 13'(wr_cur >> 1);

    col_ext = OW'(s2_col_r);
    off_ext = OW'(run_off);
    w_ext_o = OW'(w) - OW'(1);
    if (!s2_row_r[0]) begin
      mcol_full = (col_ext >= off_ext) ? col_ext - off_ext : '0;
    end else begin
      mcol_full = (col_ext + off_ext <= w_ext_o) ? col_ext + off_ext : w_ext_o;
    end
    mark_col = 12'(mcol_full);
  end

  // Run-length machine: next level and counters
  always_comb begin
    level_nxt = level_cur;
    b1_nxt    = b1_cur;
    wr_nxt    = wr_cur;
    b2_nxt    = b2_cur;
    mark_hit  = 1'b0;
    unique case (level_cur)
      atbs_pkg::RUN_WHITE: begin
        if (!white) begin
          level_nxt = atbs_pkg::RUN_BLACK1;
          b1_nxt    = 12'd1;
          wr_nxt    = 12'd0;
          b2_nxt    = 12'd0;
        end
      end
      atbs_pkg::RUN_BLACK1: begin
        if (!white) begin
          b1_nxt = atbs_pkg::sat_inc(b1_cur);
        end else begin
          level_nxt = atbs_pkg::RUN_GAP;
          wr_nxt    = 12'd1;
        end
      end
      atbs_pkg::RUN_GAP: begin
        if (!white) begin
          level_nxt = atbs_pkg::RUN_BLACK2;
          b2_nxt    = 12'd1;
        end else begin
          wr_nxt = atbs_pkg::sat_inc(wr_cur);
        end
      end
      atbs_pkg::RUN_BLACK2: begin
        if (!white) begin
          b2_nxt = atbs_pkg::sat_inc(b2_cur);
        end else begin
          mark_hit  = pattern_ok;
          level_nxt = atbs_pkg::RUN_GAP;
          b1_nxt    = b2_cur;
          wr_nxt    = 12'd1;
          b2_nxt    = 12'd0;
        end
      end
      default: begin
        level_nxt = atbs_pkg::RUN_WHITE;
      end
    endcase
  end

  // Hold the run state between pixels of a row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= atbs_pkg::RUN_WHITE;
      b1_r    <= 12'd0;
      wr_r    <= 12'd0;
      b2_r    <= 12'd0;
    end else if (adv && s2_valid_r) begin
      level_r <= level_nxt;
      b1_r    <= b1_nxt;
      wr_r    <= wr_nxt;
      b2_r    <= b2_nxt;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_is_white_r     <= white;
      out_mark_valid_r   <= mark_hit;
      out_mark_column_r  <= mark_hit ? mark_col : 12'd0;
      out_pixel_row_r    <= s2_row_r;
      out_pixel_column_r <= 12'(s2_col_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_white     = out_is_white_r;
  assign out_mark_valid   = out_mark_valid_r;
  assign out_mark_column  = out_mark_column_r;
  assign out_pixel_row    = out_pixel_row_r;
  assign out_pixel_column = out_pixel_column_r;

endmodule

>>> sim/scan_checker.sv
// Result checker for the bull's-eye scanner: predicts each pixel word and compares.
`timescale 1ns / 1ps

module scan_checker #(
  parameter int MAX_COLS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_gray,
  input  logic        in_frame_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_is_white,
  input  logic        out_mark_valid,
  input  logic [11:0] out_mark_column,
  input  logic [11:0] out_pixel_row,
  input  logic [11:0] out_pixel_column,
  output int          words_pending,
  output int          mismatches
);

  localparam int unsigned LEAK_LEN = 30;

  typedef struct packed {
    logic        is_white;
    logic        mark_valid;
    logic [11:0] mark_column;
    logic [11:0] pixel_row;
    logic [11:0] pixel_column;
  } pix_word_t;

  // Register copies
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [7:0]  unit_reg;

  // Scanner state
  logic [12:0]          leak_sum;
  atbs_pkg::run_level_t level;
  logic [11:0]          black_a;
  logic [11:0]          gap_run;
  logic [11:0]          black_b;
  logic [11:0]          row;
  logic [12:0]          step;
  logic [12:0]          column_sums [0:MAX_COLS-1];

  pix_word_t expected_pixels [$];
  pix_word_t got;
  pix_word_t want;
  int        fail_count = 0;

  assign mismatches = fail_count;

  function automatic int unsigned span_width();
    int unsigned w;
    w = width_reg;
    if (w < atbs_pkg::MIN_DIM) w = atbs_pkg::MIN_DIM;
    if (w > MAX_COLS) w = MAX_COLS;
    return w;
  endfunction

  function automatic int unsigned span_height();
    int unsigned h;
    h = height_reg;
    if (h < atbs_pkg::MIN_DIM) h = atbs_pkg::MIN_DIM;
    if (h > atbs_pkg::MAX_HEIGHT) h = atbs_pkg::MAX_HEIGHT;
    return h;
  endfunction

  function automatic logic [11:0] bump(input logic [11:0] v);
    return (v < atbs_pkg::RUN_MAX) ? v + 12'd1 : atbs_pkg::RUN_MAX;
  endfunction

  function automatic void clear_runs();
    level   = atbs_pkg::RUN_WHITE;
    black_a = '0;
    gap_run = '0;
    black_b = '0;
  endfunction

  // Start the next row, wrapping past the last row without touching the sum
  function automatic void advance_row();
    int unsigned next;
    next = int'(row) + 1;
    step = '0;
    row  = (next >= span_height()) ? 12'd0 : 12'(next);
    clear_runs();
  endfunction

  // Threshold one pixel, run the ring detector and advance the scan position
  function automatic pix_word_t scan_pixel(input logic [7:0] gray, input logic fs);
    pix_word_t   r;
    int unsigned w, col, thr, gi, b1, b2, w1, s, d, e, off, mcol;
    logic        white;
    r    = '0;
    mcol = 0;
    gi   = gray;
    w    = span_width();
    if (fs) begin
      leak_sum = atbs_pkg::SUM_INIT;
      row      = '0;
      step     = '0;
      clear_runs();
    end else if (step >= w) begin
      advance_row();
    end
    col = row[0] ? (w - 1 - int'(step)) : int'(step);

    leak_sum = 13'(int'(leak_sum) + gi - int'(leak_sum) / LEAK_LEN);
    if (row != 0) begin
      thr = (int'(leak_sum) + int'(column_sums[col])) / (2 * LEAK_LEN);
    end else begin
      thr = int'(leak_sum) / LEAK_LEN;
    end
    white = !(gi * 40 < thr * 39);
    column_sums[col] = leak_sum;

    unique case (level)
      atbs_pkg::RUN_WHITE: begin
        if (!white) begin
          level   = atbs_pkg::RUN_BLACK1;
          black_a = 12'd1;
          gap_run = '0;
          black_b = '0;
        end
      end
      atbs_pkg::RUN_BLACK1: begin
        if (!white) begin
          black_a = bump(black_a);
        end else begin
          level   = atbs_pkg::RUN_GAP;
          gap_run = 12'd1;
        end
      end
      atbs_pkg::RUN_GAP: begin
        if (!white) begin
          level   = atbs_pkg::RUN_BLACK2;
          black_b = 12'd1;
        end else begin
          gap_run = bump(gap_run);
        end
      end
      default: begin
        if (!white) begin
          black_b = bump(black_b);
        end else begin
          // Second ring closed: test size and ratio of black, white, black
          b1 = black_a;
          b2 = black_b;
          w1 = gap_run;
          s  = b1 + b2;
          d  = (s > w1) ? s - w1 : w1 - s;
          e  = (b1 > b2) ? b1 - b2 : b2 - b1;
          if (b1 >= 2 && b2 >= 2 && b1 <= unit_reg && b2 <= unit_reg &&
              w1 <= 2 * int'(unit_reg) && d <= s && d <= w1 && e <= b1 && e <= b2) begin
            off = 1 + b2 + w1 / 2;
            if (!row[0]) begin
              mcol = (col >= off) ? col - off : 0;
            end else begin
              mcol = (col + off <= w - 1) ? col + off : w - 1;
            end
            r.mark_valid = 1'b1;
          end
          black_a = black_b;
          gap_run = 12'd1;
          black_b = '0;
          level   = atbs_pkg::RUN_GAP;
        end
      end
    endcase

    r.is_white     = white;
    r.mark_column  = 12'(mcol);
    r.pixel_row    = row;
    r.pixel_column = 12'(col);

    step = step + 13'd1;
    if (step >= w) advance_row();
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t scan_checker: %s expected %0d got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Track registers, predict on each pixel word, compare each result word
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = atbs_pkg::IMAGE_WIDTH_RST;
      height_reg = atbs_pkg::IMAGE_HEIGHT_RST;
      unit_reg   = atbs_pkg::MAX_UNIT_RST;
      leak_sum   = atbs_pkg::SUM_INIT;
      row        = '0;
      step       = '0;
      clear_runs();
      expected_pixels.delete();
      words_pending <= 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          atbs_pkg::CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata;
          atbs_pkg::CFG_IMAGE_HEIGHT: height_reg = cfg_wdata;
          atbs_pkg::CFG_MAX_UNIT:     unit_reg   = cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        got.is_white     = out_is_white;
        got.mark_valid   = out_mark_valid;
        got.mark_column  = out_mark_column;
        got.pixel_row    = out_pixel_row;
        got.pixel_column = out_pixel_column;
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t scan_checker: unexpected word, expected none got %h", $time, got);
        end else begin
          want = expected_pixels.pop_front();
          check_field("is_white", want.is_white, got.is_white);
          check_field("mark_valid", want.mark_valid, got.mark_valid);
          check_field("mark_column", want.mark_column, got.mark_column);
          check_field("pixel_row", want.pixel_row, got.pixel_row);
          check_field("pixel_column", want.pixel_column, got.pixel_column);
        end
      end

      // Append the prediction at the tail
      if (in_valid && !in_stall) begin
        expected_pixels.insert(expected_pixels.size(), scan_pixel(in_gray, in_frame_start));
      end
      words_pending <= expected_pixels.size();
    end
  end

endmodule

>>> sim/tb.sv
// Testbench top for the bull's-eye scanner: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CFG_SPARE   = 2'd3;
  localparam int         QUIET_LIMIT = 3000;
  localparam int         PIXEL_GOAL  = 1950;
  localparam int         HOLD_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_gray;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_stall;
  logic        out_is_white;
  logic        out_mark_valid;
  logic [11:0] out_mark_column;
  logic [11:0] out_pixel_row;
  logic [11:0] out_pixel_column;

  int   words_pending;
  int   mismatches;
  int   pixels_sent = 0;
  int   burst_left  = 0;
  int   quiet_cycles = 0;
  logic shade_dark  = 1'b0;
  int   run_left    = 0;
  int   ring_unit   = 3;
  logic noise_only  = 1'b0;

  adaptive_threshold_bullseye_scan u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_gray          (in_gray),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_white     (out_is_white),
    .out_mark_valid   (out_mark_valid),
    .out_mark_column  (out_mark_column),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_column (out_pixel_column)
  );

  scan_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_gray          (in_gray),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_white     (out_is_white),
    .out_mark_valid   (out_mark_valid),
    .out_mark_column  (out_mark_column),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_column (out_pixel_column),
    .words_pending    (words_pending),
    .mismatches       (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Write one register, then leave the port quiet
  task automatic cfg_write(input logic [1:0] idx, input logic [12:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel word in bursts with random gaps; return once it is taken
  task automatic push_pixel(input logic [7:0] gray, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_gray        <= gray;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  // Drop valid and wait until every result word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly ring-like runs of dark and light with a scale that wanders; some noise
  function automatic logic [7:0] next_gray();
    if (noise_only || $urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    if (run_left == 0) begin
      if ($urandom_range(0, 15) == 0) begin
        ring_unit = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
      end
      shade_dark = !shade_dark;
      run_left = shade_dark ? ring_unit + $urandom_range(0, 1)
                            : 2 * ring_unit - 1 + $urandom_range(0, 2);
    end
    run_left--;
    return shade_dark ? 8'($urandom_range(0, 50)) : 8'($urandom_range(170, 255));
  endfunction

  // Stimulus
  initial begin
    int unsigned w, h, u, count;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= atbs_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_gray        <= '0;
    in_frame_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Clamped small frame, zero unit, gray extremes and a wrap past the last row
    cfg_write(atbs_pkg::CFG_IMAGE_WIDTH, 13'd0);
    cfg_write(atbs_pkg::CFG_IMAGE_HEIGHT, 13'd1);
    cfg_write(atbs_pkg::CFG_MAX_UNIT, 13'd0);
    for (int k = 0; k < 10; k++) push_pixel(k[0] ? 8'd255 : 8'd0, k == 0);
    drain();

    // Shrink the width mid-row so the row change comes before the next pixel
    cfg_write(atbs_pkg::CFG_IMAGE_WIDTH, 13'd4);
    cfg_write(atbs_pkg::CFG_IMAGE_HEIGHT, 13'h1fff);
    cfg_write(atbs_pkg::CFG_MAX_UNIT, 13'h1fff);
    for (int k = 0; k < 11; k++) push_pixel(8'($urandom_range(0, 255)), k == 0);
    drain();
    cfg_write(atbs_pkg::CFG_IMAGE_WIDTH, 13'd3);
    for (int k = 0; k < 2; k++) push_pixel(8'($urandom_range(0, 255)), 1'b0);
    drain();

    // Widest row, and a write to the unused index
    cfg_write(atbs_pkg::CFG_IMAGE_WIDTH, 13'h1fff);
    cfg_write(CFG_SPARE, 13'($urandom_range(0, 8191)));
    for (int k = 0; k < 3; k++) push_pixel(8'($urandom_range(0, 255)), k == 0);
    drain();

    // Random phases; each opens a frame so the line store is filled before use
    while (pixels_sent < PIXEL_GOAL) begin
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 8191);
      else if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 2);
      else w = $urandom_range(3, 40);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 12);
      case ($urandom_range(0, 9))
        0:       u = 0;
        1:       u = 1;
        2:       u = 255;
        default: u = $urandom_range(4, 24);
      endcase
      cfg_write(atbs_pkg::CFG_IMAGE_WIDTH, 13'(w));
      cfg_write(atbs_pkg::CFG_IMAGE_HEIGHT, 13'(h));
      cfg_write(atbs_pkg::CFG_MAX_UNIT, {5'($urandom_range(0, 31)), 8'(u)});
      if ($urandom_range(0, 5) == 0) cfg_write(CFG_SPARE, 13'($urandom_range(0, 8191)));

      count      = (w > 64) ? $urandom_range(20, 40) : $urandom_range(60, 200);
      if (count > PIXEL_GOAL - pixels_sent) count = PIXEL_GOAL - pixels_sent;
      noise_only = ($urandom_range(0, 4) == 0);
      run_left   = 0;
      shade_dark = 1'b0;
      ring_unit  = $urandom_range(2, 6);
      for (int k = 0; k < count; k++) begin
        push_pixel(next_gray(), k == 0 || $urandom_range(0, 299) == 0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Receiver stalls: stretches of none, light and heavy back-pressure, plus long holds
  initial begin
    int span, heat, cyc, holds;
    out_stall <= 1'b0;
    cyc   = 0;
    holds = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      span = $urandom_range(20, 200);
      case ($urandom_range(0, 2))
        0:       heat = 0;
        1:       heat = 25;
        default: heat = 75;
      endcase
      repeat (span) begin
        // Hold off while the sender keeps offering so the input side backs up
        if (holds < 2 && cyc >= (holds == 0 ? 1500 : 5000) && in_valid) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          cyc += HOLD_CYCLES;
          holds++;
        end
        out_stall <= ($urandom_range(0, 99) < heat);
        @(posedge clk);
        cyc++;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule

>>> adaptive_threshold_bullseye_scan.f
rtl/core/atbs_pkg.sv
rtl/core/atbs_front.sv
rtl/core/atbs_queue.sv
rtl/core/atbs_back.sv
rtl/core/adaptive_threshold_bullseye_scan.sv
sim/scan_checker.sv
sim/tb.sv
